FILE: src/satlb_pkg.sv
// Shared types and constants for the set-associative TLB.
// No dependencies.
`default_nettype none
package satlb_pkg;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam int HASH_SHIFT = 12;

  typedef enum logic [2:0] {
    K_LOOKUP = 3'd0, K_INSERT = 3'd1, K_INV_KEY = 3'd2, K_INV_SCAN = 3'd3,
    K_INV_PID = 3'd4, K_FLUSH = 3'd5, K_CLR_CNT = 3'd6, K_RESET = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_REDUCE, S_READ, S_EXEC, S_SCAN_RD, S_SCAN_WB, S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] pid;
    logic [31:0] page;
    logic [31:0] phys;
    logic [15:0] flags;
    logic [31:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

FILE: src/satlb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module satlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: src/set_assoc_tlb_age_replace.sv
// Set-associative TLB, one set per memory row, age-based replacement.
// Lookup/insert/key invalidate step from the accepting edge through hash, reduce,
// read, execute/write-back and done to the edge that takes the result; the next start
// is taken at that same edge. Scan/pid invalidate visit every row with a read and a
// write-back state. Flush, clear and reset go straight to done. busy is high meanwhile.
// Valid bits are flip-flops cleared by reset; the RAM needs no clearing.
// One result strobe per transaction; the receiver cannot stall.
`default_nettype none
module set_assoc_tlb_age_replace #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_pid,
  input  wire logic [31:0] in_va_page,
  input  wire logic [31:0] in_pa_page,
  input  wire logic [15:0] in_entry_flags,
  output logic             out_valid,
  output logic             out_hit,
  output logic [31:0]      out_found_page,
  output logic [15:0]      out_found_flags,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count,
  output logic [31:0]      out_evict_count,
  output logic [31:0]      out_invalidate_count,
  output logic [31:0]      out_lookup_count
);
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int EW = satlb_pkg::ENTRY_W;
  localparam int RW = EW * NUM_WAYS;
  localparam int RB = SW + 1;
  localparam logic [32:0] NSETS = 33'(NUM_SETS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_SETS));

  satlb_pkg::state_t state_r, state_nxt;
  logic [2:0]  kind_r;
  logic [31:0] pid_r, va_r, pa_r;
  logic [15:0] fl_r;
  logic [31:0] hash_r;
  logic [31:0] q_r;
  logic [SW-1:0] set_r;
  logic [NUM_WAYS-1:0] valid_r [NUM_SETS];
  logic [31:0] c_hit_r, c_miss_r, c_evict_r, c_inval_r, c_look_r;
  logic hit_r;
  logic [31:0] fpage_r;
  logic [15:0] fflags_r;

  logic          ram_we;
  logic [SW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  satlb_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [31:0] hash_c;
  assign hash_c = in_pid ^ (in_va_page >> satlb_pkg::HASH_SHIFT)
                  ^ (in_va_page * satlb_pkg::HASH_MUL);

  // set index: mask for a power of two, else reciprocal quotient estimate (off by
  // at most one) followed by one compare and subtract on the low bits
  logic [SW-1:0] set_mod;
  logic [RB-1:0] rem_c;
  always_comb begin
    rem_c = hash_r[RB-1:0] - q_r[RB-1:0] * RB'(NUM_SETS);
    if ((NUM_SETS & (NUM_SETS - 1)) == 0) set_mod = SW'(hash_r & 32'(NUM_SETS - 1));
    else if (rem_c >= RB'(NUM_SETS)) set_mod = SW'(rem_c - RB'(NUM_SETS));
    else set_mod = SW'(rem_c);
  end

  // way decode of the read row
  satlb_pkg::entry_t ent [NUM_WAYS];
  logic [NUM_WAYS-1:0] vrow, match;
  always_comb begin
    vrow = valid_r[set_r];
    for (int w = 0; w < NUM_WAYS; w++) begin
      ent[w] = ram_rdata[w*EW +: EW];
      match[w] = vrow[w] && ent[w].pid == pid_r &&
                 (kind_r == satlb_pkg::K_INV_PID || ent[w].page == va_r);
    end
  end

  logic hit_any, empty_any;
  logic [WW-1:0] hit_w, empty_w, min_w, vict_w;
  logic [31:0] min_age;
  logic [4:0] nmatch;
  always_comb begin
    hit_any = 1'b0; hit_w = '0; empty_any = 1'b0; empty_w = '0;
    min_w = '0; min_age = ent[0].age; nmatch = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin hit_any = 1'b1; hit_w = WW'(w); end
      if (!vrow[w]) begin empty_any = 1'b1; empty_w = WW'(w); end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (ent[w].age < min_age) begin min_age = ent[w].age; min_w = WW'(w); end
      nmatch = nmatch + 5'(match[w]);
    end
    vict_w = empty_any ? empty_w : min_w;
  end

  satlb_pkg::entry_t new_ent;
  logic [WW-1:0] wr_w;
  logic wr_en;
  always_comb begin
    new_ent = ent[hit_w];
    wr_w = hit_w;
    wr_en = 1'b0;
    if (kind_r == satlb_pkg::K_LOOKUP) begin
      wr_en = hit_any;
      new_ent.age = ent[hit_w].age + 32'd1;
    end else if (kind_r == satlb_pkg::K_INSERT) begin
      wr_en = 1'b1;
      if (hit_any) begin
        new_ent.phys = pa_r; new_ent.flags = fl_r;
        new_ent.age = ent[hit_w].age + 32'd1;
      end else begin
        wr_w = vict_w;
        new_ent = '{pid: pid_r, page: va_r, phys: pa_r, flags: fl_r, age: 32'd1};
      end
    end
    ram_wdata = ram_rdata;
    ram_wdata[wr_w*EW +: EW] = new_ent;
    ram_we = (state_r == satlb_pkg::S_EXEC) && wr_en;
  end

  logic [SW:0] scan_r;
  assign ram_addr = (state_r == satlb_pkg::S_SCAN_RD) ? scan_r[SW-1:0] : set_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      satlb_pkg::S_IDLE: if (start) begin
        if (in_kind == satlb_pkg::K_INV_SCAN || in_kind == satlb_pkg::K_INV_PID)
          state_nxt = satlb_pkg::S_SCAN_RD;
        else if (in_kind == satlb_pkg::K_FLUSH || in_kind == satlb_pkg::K_CLR_CNT ||
                 in_kind == satlb_pkg::K_RESET)
          state_nxt = satlb_pkg::S_DONE;
        else state_nxt = satlb_pkg::S_HASH;
      end
      satlb_pkg::S_HASH:    state_nxt = satlb_pkg::S_REDUCE;
      satlb_pkg::S_REDUCE:  state_nxt = satlb_pkg::S_READ;
      satlb_pkg::S_READ:    state_nxt = satlb_pkg::S_EXEC;
      satlb_pkg::S_EXEC:    state_nxt = satlb_pkg::S_DONE;
      satlb_pkg::S_SCAN_RD: state_nxt = satlb_pkg::S_SCAN_WB;
      satlb_pkg::S_SCAN_WB:
        state_nxt = ({1'b0, scan_r} + 33'd1 == NSETS) ? satlb_pkg::S_DONE
                                                      : satlb_pkg::S_SCAN_RD;
      satlb_pkg::S_DONE:    state_nxt = satlb_pkg::S_IDLE;
      default:              state_nxt = satlb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != satlb_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= satlb_pkg::S_IDLE;
      out_valid <= 1'b0;
      c_hit_r <= '0; c_miss_r <= '0; c_evict_r <= '0; c_inval_r <= '0; c_look_r <= '0;
      for (int s = 0; s < NUM_SETS; s++) valid_r[s] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == satlb_pkg::S_DONE);
      case (state_r)
        satlb_pkg::S_IDLE: if (start) begin
          kind_r <= in_kind; pid_r <= in_pid; va_r <= in_va_page;
          pa_r <= in_pa_page; fl_r <= in_entry_flags;
          hash_r <= hash_c; hit_r <= 1'b0; fpage_r <= '0; fflags_r <= '0;
          scan_r <= '0; set_r <= '0;
          if (in_kind == satlb_pkg::K_INV_SCAN) c_inval_r <= c_inval_r + 32'd1;
          if (in_kind == satlb_pkg::K_FLUSH || in_kind == satlb_pkg::K_RESET)
            for (int s = 0; s < NUM_SETS; s++) valid_r[s] <= '0;
          if (in_kind == satlb_pkg::K_FLUSH) c_inval_r <= c_inval_r + 32'd1;
          if (in_kind == satlb_pkg::K_CLR_CNT || in_kind == satlb_pkg::K_RESET) begin
            c_hit_r <= '0; c_miss_r <= '0; c_evict_r <= '0; c_inval_r <= '0;
            c_look_r <= '0;
          end
        end
        satlb_pkg::S_HASH: q_r <= 32'(({32'd0, hash_r} * {32'd0, RECIP}) >> 32);
        satlb_pkg::S_REDUCE: set_r <= set_mod;
        satlb_pkg::S_EXEC: begin
          case (kind_r)
            satlb_pkg::K_LOOKUP: begin
              c_look_r <= c_look_r + 32'd1;
              if (hit_any) begin
                c_hit_r <= c_hit_r + 32'd1; hit_r <= 1'b1;
                fpage_r <= ent[hit_w].phys; fflags_r <= ent[hit_w].flags;
              end else c_miss_r <= c_miss_r + 32'd1;
            end
            satlb_pkg::K_INSERT: begin
              if (!hit_any) begin
                valid_r[set_r][vict_w] <= 1'b1;
                if (!empty_any) c_evict_r <= c_evict_r + 32'd1;
              end
            end
            satlb_pkg::K_INV_KEY: begin
              valid_r[set_r] <= vrow & ~match;
              c_inval_r <= c_inval_r + 32'(nmatch);
            end
            default: ;
          endcase
        end
        satlb_pkg::S_SCAN_RD: set_r <= scan_r[SW-1:0];
        satlb_pkg::S_SCAN_WB: begin
          valid_r[set_r] <= vrow & ~match;
          if (kind_r == satlb_pkg::K_INV_PID) c_inval_r <= c_inval_r + 32'(nmatch);
          scan_r <= scan_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_hit = hit_r;
  assign out_found_page = fpage_r;
  assign out_found_flags = fflags_r;
  assign out_hit_count = c_hit_r;
  assign out_miss_count = c_miss_r;
  assign out_evict_count = c_evict_r;
  assign out_invalidate_count = c_inval_r;
  assign out_lookup_count = c_look_r;
endmodule
`default_nettype wire
